FILE: src/pti_pkg.sv
// Package: request types and controller/datapath command and status structs.
`timescale 1ns / 1ps
`default_nettype none
package pti_pkg;

    localparam int OUT_W = 13;

    typedef struct packed {
        logic [4:0] symbol;
        logic       restart;
    } t_in_req;

    typedef struct packed {
        logic [OUT_W-1:0] suffix_node;
        logic [OUT_W-1:0] suffix_length;
        logic [OUT_W-1:0] suffix_count;
        logic             created;
        logic             overflow;
    } t_out_req;

    typedef struct packed {
        logic clear;
        logic start;
        logic rd_node_x;
        logic rd_node_child;
        logic step;
        logic found;
        logic rd_text;
        logic rd_edge;
        logic begin2;
        logic out_exist;
        logic create;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic start_ovf;
        logic x_odd;
        logic j_neg;
        logic text_eq;
        logic child_ok;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/pti_ctrl.sv
// Controller: sequences the suffix-link walks, edge lookup and node creation.
`timescale 1ns / 1ps
`default_nettype none
module pti_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire pti_pkg::t_sts i_sts,
    output pti_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_NRD   = 9'b000000100,
        S_NCHK  = 9'b000001000,
        S_TCMP  = 9'b000010000,
        S_ERD   = 9'b000100000,
        S_CRD   = 9'b001000000,
        S_CCHK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_walk2, n_walk2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_walk2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk2 <= n_walk2;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_walk2 = r_walk2;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_walk2     = 1'b0;
                    n_state     = i_sts.start_ovf ? S_DONE : S_NRD;
                end
            end
            S_NRD: begin
                o_cmd.rd_node_x = 1'b1;
                n_state = S_NCHK;
            end
            S_NCHK: begin
                if (i_sts.x_odd) begin
                    o_cmd.found = !r_walk2;
                    n_state = S_ERD;
                end else if (i_sts.j_neg) begin
                    o_cmd.step = 1'b1;
                    n_state = S_NRD;
                end else begin
                    o_cmd.rd_text = 1'b1;
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                if (i_sts.text_eq) begin
                    o_cmd.found = !r_walk2;
                    n_state = S_ERD;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_NRD;
                end
            end
            S_ERD: begin
                o_cmd.rd_edge = 1'b1;
                n_state = S_CRD;
            end
            S_CRD: begin
                o_cmd.rd_node_child = 1'b1;
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (r_walk2) begin
                    o_cmd.create = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.child_ok) begin
                    o_cmd.out_exist = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.begin2 = 1'b1;
                    n_walk2 = 1'b1;
                    n_state = S_NRD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/pti_dp.sv
// Datapath: text, node and edge memories, walk registers and output register.
`timescale 1ns / 1ps
`default_nettype none
module pti_dp #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pti_pkg::t_cmd     i_cmd,
    input  wire pti_pkg::t_in_req  i_in_req,
    input  wire logic              i_out_stall,
    output pti_pkg::t_sts          o_sts,
    output logic                   o_out_valid,
    output pti_pkg::t_out_req      o_out_req
);
    localparam int NW  = $clog2(MAX_LEN + 2);
    localparam int PW  = $clog2(MAX_LEN + 1);
    localparam int TAW = $clog2(MAX_LEN);
    localparam int CW  = $clog2(ALPHABET);
    localparam int EAW = NW + CW;

    typedef struct packed {
        logic [PW-1:0] len;
        logic [NW-1:0] link;
        logic [PW-1:0] depth;
        logic [NW-1:0] parent;
        logic [CW-1:0] letter;
    } t_info;

    logic [CW-1:0] text_mem [0:MAX_LEN-1];
    t_info         node_mem [0:MAX_LEN+1];
    logic [NW-1:0] edge_mem [0:(2**EAW)-1];

    logic [CW-1:0]  r_c;
    logic [PW-1:0]  r_pos;
    logic [NW-1:0]  r_ntotal, r_last, r_x;
    t_info          r_info_q;
    logic           r_rd_root, r_rd_odd;
    logic [CW-1:0]  r_text_q;
    logic [NW-1:0]  r_edge_q;
    logic [NW-1:0]  r_xnode, r_xlink;
    logic [PW-1:0]  r_xlen;
    logic           r_xodd;
    logic [EAW-1:0] r_clr;
    pti_pkg::t_out_req r_res, r_out;
    logic           r_ovalid;

    logic [31:0]   sym32, c32;
    logic [CW-1:0] c_in;
    logic [PW-1:0] p_eff;
    logic [PW-1:0] eff_len, eff_depth;
    logic [NW-1:0] eff_link, eff_parent;
    logic [CW-1:0] eff_letter;
    logic [PW:0]   j_full;
    logic [NW-1:0] rd_addr;
    logic          rd_en;
    logic [NW-1:0] new_node;
    logic [PW-1:0] new_len, new_depth;
    logic [NW-1:0] new_link;
    logic [31:0]   w_node, w_len, w_depth;
    logic [31:0]   e_node, e_len, e_depth;

    always_comb begin
        sym32 = {27'd0, i_in_req.symbol};
        c32   = (sym32 >= 32'(ALPHABET)) ? 32'(ALPHABET - 1) : sym32;
        c_in  = c32[CW-1:0];
        p_eff = i_in_req.restart ? '0 : r_pos;
    end

    always_comb begin
        if (r_rd_root) begin
            eff_len    = '0;
            eff_link   = NW'(1);
            eff_depth  = '0;
            eff_parent = '0;
            eff_letter = '0;
        end else begin
            eff_len    = r_info_q.len;
            eff_link   = r_info_q.link;
            eff_depth  = r_info_q.depth;
            eff_parent = r_info_q.parent;
            eff_letter = r_info_q.letter;
        end
        j_full    = {1'b0, r_pos} - {1'b0, eff_len} - (PW+1)'(1);
        rd_addr   = i_cmd.rd_node_child ? r_edge_q : r_x;
        rd_en     = i_cmd.rd_node_x | i_cmd.rd_node_child;
        new_node  = r_ntotal + NW'(1);
        new_len   = r_xodd ? PW'(1) : r_xlen + PW'(2);
        new_link  = o_sts.child_ok ? r_edge_q : '0;
        new_depth = (o_sts.child_ok ? eff_depth : '0) + PW'(1);
        w_node    = 32'(new_node);
        w_len     = 32'(new_len);
        w_depth   = 32'(new_depth);
        e_node    = 32'(r_edge_q);
        e_len     = 32'(eff_len);
        e_depth   = 32'(eff_depth);
    end

    always_comb begin
        o_sts.clr_done  = (r_clr == {EAW{1'b1}});
        o_sts.start_ovf = !i_in_req.restart && (32'(r_pos) >= 32'(MAX_LEN));
        o_sts.x_odd     = r_rd_odd;
        o_sts.j_neg     = j_full[PW];
        o_sts.text_eq   = (r_text_q == r_c);
        o_sts.child_ok  = (r_edge_q >= NW'(2)) && (r_edge_q <= r_ntotal)
                          && (eff_parent == r_x) && (eff_letter == r_c);
        o_sts.out_free  = !r_ovalid || !i_out_stall;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !o_sts.start_ovf) text_mem[p_eff[TAW-1:0]] <= c_in;
        if (i_cmd.rd_text) r_text_q <= text_mem[j_full[TAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            node_mem[new_node] <= '{len: new_len, link: new_link, depth: new_depth,
                                    parent: r_xnode, letter: r_c};
        end
        if (rd_en) begin
            r_info_q  <= node_mem[rd_addr];
            r_rd_root <= (rd_addr < NW'(2));
            r_rd_odd  <= (rd_addr == NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) edge_mem[r_clr] <= '0;
        else if (i_cmd.create) edge_mem[{r_xnode, r_c}] <= new_node;
        if (i_cmd.rd_edge) r_edge_q <= edge_mem[{r_x, r_c}];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ntotal <= NW'(1);
            r_last   <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear && !o_sts.clr_done) r_clr <= r_clr + EAW'(1);
            if (i_cmd.start) begin
                r_pos <= p_eff;
                if (i_in_req.restart) begin
                    r_ntotal <= NW'(1);
                    r_last   <= '0;
                end
            end
            if (i_cmd.out_exist) begin
                r_last <= r_edge_q;
                r_pos  <= r_pos + PW'(1);
            end
            if (i_cmd.create) begin
                r_ntotal <= new_node;
                r_last   <= new_node;
                r_pos    <= r_pos + PW'(1);
            end
            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_c <= c_in;
            r_x <= i_in_req.restart ? '0 : r_last;
            r_res <= '{suffix_node: '0, suffix_length: '0, suffix_count: '0,
                       created: 1'b0, overflow: o_sts.start_ovf};
        end
        if (i_cmd.step) r_x <= eff_link;
        if (i_cmd.found) begin
            r_xnode <= r_x;
            r_xlen  <= eff_len;
            r_xlink <= eff_link;
            r_xodd  <= r_rd_odd;
        end
        if (i_cmd.begin2) r_x <= r_xlink;
        if (i_cmd.out_exist) begin
            r_res <= '{suffix_node: e_node[12:0], suffix_length: e_len[12:0],
                       suffix_count: e_depth[12:0], created: 1'b0, overflow: 1'b0};
        end
        if (i_cmd.create) begin
            r_res <= '{suffix_node: w_node[12:0], suffix_length: w_len[12:0],
                       suffix_count: w_depth[12:0], created: 1'b1, overflow: 1'b0};
        end
        if (i_cmd.emit) r_out <= r_res;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_req   = r_out;
endmodule
`default_nettype wire

FILE: src/palindrome_tree_insert.sv
// Palindromic tree builder: one letter per request, one result per request.
// Each request walks the suffix links from the last node, reading each node and comparing the
// text letter where needed, then reads the edge and the child; making a node adds a second walk.
// A new request is taken only after the last result is registered; a stalled result holds off the next one.
// Reset clears the edge memory with no request taken; a restart request empties the tree
// at once.
`timescale 1ns / 1ps
`default_nettype none
module palindrome_tree_insert #(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pti_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pti_pkg::t_out_req      o_out_req
);
    pti_pkg::t_cmd cmd;
    pti_pkg::t_sts sts;

    pti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pti_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_req    (i_in_req),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );
endmodule
`default_nettype wire

FILE: test/tb_palindrome_tree_insert.sv
// Testbench for palindrome_tree_insert: bursty letter requests checked against an eertree model.
`timescale 1ns / 1ps
`default_nettype none
module tb_palindrome_tree_insert;
    localparam int MAXL      = 4096;
    localparam int ALPHA     = 26;
    localparam int NODES     = MAXL + 2;
    localparam int ODD       = 1;
    localparam int EVEN      = 0;
    localparam int OW        = pti_pkg::OUT_W;
    localparam int N_ITEMS   = 1250;
    localparam int LONG_HOLD = 400;

    typedef struct {
        pti_pkg::t_in_req req;
        bit               drain;
    } t_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    pti_pkg::t_in_req  i_in_req;
    logic              o_out_valid;
    logic              i_out_stall;
    pti_pkg::t_out_req o_out_req;

    t_item             pend_q[$];
    pti_pkg::t_out_req exp_q[$];

    int unsigned text_m  [MAXL];
    int          len_m   [NODES];
    int unsigned link_m  [NODES];
    int unsigned depth_m [NODES];
    int unsigned edge_m  [NODES][ALPHA];
    int unsigned ntotal_m;
    int unsigned last_m;
    int unsigned pos_m;

    int n_sent    = 0;
    int n_recv    = 0;
    int n_err     = 0;
    int n_created = 0;
    int n_restart = 0;
    int n_drain   = 0;
    int burst_left;
    int gap_left;
    int hold_left;
    bit hold_done;
    bit prev_wait;
    pti_pkg::t_out_req prev_out;

    palindrome_tree_insert #(
        .MAX_LEN  (MAXL),
        .ALPHABET (ALPHA)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report(input string what);
        n_err++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic void model_empty();
        int unsigned rows;
        rows = ntotal_m + 1;
        if (rows > NODES) rows = NODES;
        for (int unsigned r = 0; r < rows; r++)
            for (int k = 0; k < ALPHA; k++) edge_m[r][k] = 0;
        len_m[EVEN]   = 0;
        len_m[ODD]    = -1;
        link_m[EVEN]  = ODD;
        link_m[ODD]   = ODD;
        depth_m[EVEN] = 0;
        depth_m[ODD]  = 0;
        ntotal_m = 1;
        last_m   = EVEN;
        pos_m    = 0;
    endfunction

    function automatic void model_init();
        for (int i = 0; i < MAXL; i++) text_m[i] = 0;
        for (int i = 0; i < NODES; i++) begin
            len_m[i]   = 0;
            link_m[i]  = 0;
            depth_m[i] = 0;
            for (int k = 0; k < ALPHA; k++) edge_m[i][k] = 0;
        end
        ntotal_m = NODES - 1;
        model_empty();
    endfunction

    function automatic int unsigned model_ext(int unsigned x0, int unsigned p, int unsigned c);
        int unsigned x;
        int          j;
        bit          done;
        x    = x0;
        done = 1'b0;
        while (!done) begin
            j = int'(p) - len_m[x] - 1;
            if ((j >= 0 && j < MAXL && text_m[j] == c) || x == ODD) done = 1'b1;
            else x = link_m[x];
        end
        return x;
    endfunction

    function automatic pti_pkg::t_out_req model_step(pti_pkg::t_in_req req);
        pti_pkg::t_out_req res;
        int unsigned c;
        int unsigned p;
        int unsigned x;
        int unsigned child;
        int unsigned node;
        int unsigned y;
        int unsigned lnk;
        res = '0;
        if (req.restart) model_empty();
        c = req.symbol;
        if (c >= ALPHA) c = ALPHA - 1;
        if (pos_m >= MAXL) begin
            res.overflow = 1'b1;
            return res;
        end
        p = pos_m;
        text_m[p] = c;
        x = model_ext(last_m, p, c);
        child = edge_m[x][c];
        if (child == 0 && ntotal_m + 1 < NODES) begin
            node = ntotal_m + 1;
            len_m[node] = len_m[x] + 2;
            y = model_ext(link_m[x], p, c);
            lnk = edge_m[y][c];
            link_m[node]  = lnk;
            depth_m[node] = 1 + depth_m[lnk];
            edge_m[x][c]  = node;
            ntotal_m      = node;
            child         = node;
            res.created   = 1'b1;
        end
        last_m = child;
        pos_m  = p + 1;
        res.suffix_node   = OW'(child);
        res.suffix_length = OW'(len_m[child]);
        res.suffix_count  = OW'(depth_m[child]);
        return res;
    endfunction

    // stimulus: runs over small alphabets to grow long palindromes, some full-range runs
    initial begin : stim
        t_item it;
        int    span;
        int    lim;
        model_init();
        span = 0;
        lim  = 2;
        for (int i = 0; i < N_ITEMS; i++) begin
            if (span == 0) begin
                span = $urandom_range(20, 120);
                case ($urandom_range(0, 4))
                    0: lim = 1;
                    1: lim = 2;
                    2: lim = 3;
                    3: lim = 5;
                    default: lim = 32;
                endcase
            end
            span--;
            it.req.symbol  = 5'($urandom_range(0, lim - 1));
            it.req.restart = (i > 0) && ((i == 900) || ($urandom_range(0, 199) == 0));
            it.drain       = (i == N_ITEMS / 2) || ($urandom_range(0, 249) == 0);
            pend_q.push_back(it);
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_req   <= '0;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end else begin : drv
            bit take;
            bit nv;
            take = i_in_valid && !o_in_stall;
            if (take) begin
                exp_q.push_back(model_step(i_in_req));
                if (i_in_req.restart) n_restart++;
                n_sent++;
            end
            if (!(i_in_valid && !take)) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0 && !(pend_q[0].drain && exp_q.size() > 0)) begin
                    if (pend_q[0].drain) n_drain++;
                    nv = 1'b1;
                    i_in_req <= pend_q[0].req;
                    void'(pend_q.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
                i_in_valid <= nv;
            end
        end
    end

    // receiver stall pattern with one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (!hold_done && n_recv >= 300) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < (((n_recv % 400) < 200) ? 15 : 55));
            end
        end
    end

    task automatic finish_run();
        $display("Checked %0d letter requests (%0d restarts, %0d new nodes) sent in bursts,",
                 n_sent, n_restart, n_created);
        $display("with random result stalls, one %0d-cycle hold and %0d waits for an empty block.",
                 LONG_HOLD, n_drain);
        if (n_err == 0 && n_sent == N_ITEMS) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (prev_wait && (!o_out_valid || o_out_req !== prev_out))
                report("result changed while stalled");
            if (o_out_valid && !i_out_stall) begin
                if (exp_q.size() == 0) begin
                    report("result with no request outstanding");
                end else begin : chk
                    pti_pkg::t_out_req e;
                    e = exp_q.pop_front();
                    if (o_out_req !== e)
                        report($sformatf({"node %0d/%0d len %0d/%0d count %0d/%0d",
                                          " created %0b/%0b ovf %0b/%0b (got/exp)"},
                                         o_out_req.suffix_node, e.suffix_node,
                                         o_out_req.suffix_length, e.suffix_length,
                                         o_out_req.suffix_count, e.suffix_count,
                                         o_out_req.created, e.created,
                                         o_out_req.overflow, e.overflow));
                    if (e.created) n_created++;
                end
                n_recv++;
                if (n_recv == N_ITEMS) finish_run();
            end
            prev_wait = o_out_valid && i_out_stall;
            prev_out  = o_out_req;
        end else begin
            prev_wait = 1'b0;
        end
    end

    initial begin
        #20000000;
        $display("Run stopped at the time limit with %0d of %0d results", n_recv, N_ITEMS);
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

FILE: palindrome_tree_insert.f
src/pti_pkg.sv
src/pti_ctrl.sv
src/pti_dp.sv
src/palindrome_tree_insert.sv
test/tb_palindrome_tree_insert.sv
